### hdl/irpk_pkg.sv
// Package for the IR pulse/space transmit packer.
// Holds constants, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package irpk_pkg;

  localparam int DUR_W       = 24;
  localparam int BYTE_W      = 8;
  localparam int PAIR_W      = 2 * BYTE_W;
  localparam int CHUNK_UNITS = 255;
  localparam int US_SCALE    = 100;
  localparam int ROUND_BIAS  = 50;
  localparam int UNIT_DIV    = 1285;

  // Numerator of the unit conversion
  localparam int NUM_W  = $clog2((2 ** DUR_W - 1) * US_SCALE + ROUND_BIAS + 1);

  // Reciprocal of UNIT_DIV: (n * RECIP_MULT) >> RECIP_SHIFT is exact for n below 2**LOW_W
  localparam int LOW_W       = 25;
  localparam int RECIP_W     = 26;
  localparam int RECIP_MULT  = 53478193;
  localparam int RECIP_SHIFT = 36;
  localparam int PROD_W      = LOW_W + RECIP_W;

  // Steps of one conversion before its result is stored
  localparam int CONV_STEPS = 1;
  localparam int DCNT_W     = $clog2(CONV_STEPS + 1);

  localparam logic ACT_VALUE = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;
  localparam logic REQ_SEND  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_P,
    ST_DIV_S,
    ST_SPLIT_P,
    ST_SPLIT_S,
    ST_PUT_MAIN,
    ST_TRAIL,
    ST_FLUSH_BUF,
    ST_FLUSH_REQ,
    ST_DRAIN
  } irpk_state_t;

  typedef struct packed {
    logic take_in;
    logic div_step;
    logic p_store;
    logic s_store;
    logic split_p;
    logic split_s;
    logic put_main;
    logic put_trail;
    logic flush_buf;
    logic flush_req;
    logic drain;
  } irpk_cmd_t;

  typedef struct packed {
    logic exp_space;
    logic in_flush;
    logic act_flush;
    logic div_done;
    logic p_big;
    logic s_big;
    logic trail_zero;
    logic slot_ok;
  } irpk_stat_t;

endpackage

`default_nettype wire

### hdl/irpk_ifs.sv
// Valid/ready channel interfaces for the IR packer input and result items.
// Depends on irpk_pkg for field widths.
`default_nettype none

interface irpk_in_if
  import irpk_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [DUR_W-1:0] duration_us;

  modport source (output valid, output action, output duration_us, input ready);
  modport sink   (input valid, input action, input duration_us, output ready);
endinterface

interface irpk_out_if
  import irpk_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              request_kind;
  logic [PAIR_W-1:0] newer_pair;
  logic [PAIR_W-1:0] older_pair;
  logic              last;

  modport source (output valid, output request_kind, output newer_pair,
                  output older_pair, output last, input ready);
  modport sink   (input valid, input request_kind, input newer_pair,
                  input older_pair, input last, output ready);
endinterface

`default_nettype wire

### hdl/ir_pulse_space_tx_packer.sv
// IR pulse/space transmit packer. A pulse item is taken with no result.
// A space item runs two unit conversions, then split, main pair, trailing chunks and drain,
// splitting off each 255-unit pulse chunk and each space chunk, stalling while results wait.
// A flush passes the flush-buffer, flush-request and drain steps, after the space steps when
// a pulse dangles; the last result is offered as the next item is taken.
// Synchronous active-low reset empties the pair buffer and all result stages.
`default_nettype none

module ir_pulse_space_tx_packer
  import irpk_pkg::*;
#(
  parameter int MAX_CHUNKS = 60
) (
  input wire          clk,
  input wire          rst_n,
  irpk_in_if.sink     in_chan,
  irpk_out_if.source  out_chan
);

  irpk_cmd_t  cmd;
  irpk_stat_t stat;
  logic       in_ready;

  assign in_chan.ready = in_ready;

  irpk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  irpk_dp #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_chan.action),
    .in_duration_us   (in_chan.duration_us),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_request_kind (out_chan.request_kind),
    .out_newer_pair   (out_chan.newer_pair),
    .out_older_pair   (out_chan.older_pair),
    .out_last         (out_chan.last)
  );

endmodule

`default_nettype wire

### hdl/irpk_ctrl.sv
// Sequencing state machine of the IR packer: conversion, splitting, flush.
// Depends on irpk_pkg; drives the datapath through irpk_cmd_t.
`default_nettype none

module irpk_ctrl
  import irpk_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  irpk_stat_t stat,
  output irpk_cmd_t  cmd
);

  irpk_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.exp_space) begin
            state_nxt = ST_DIV_P;
          end else if (stat.in_flush) begin
            state_nxt = ST_FLUSH_BUF;
          end
        end
      end
      ST_DIV_P:     if (stat.div_done) state_nxt = ST_DIV_S;
      ST_DIV_S:     if (stat.div_done) state_nxt = ST_SPLIT_P;
      ST_SPLIT_P:   if (!stat.p_big) state_nxt = ST_SPLIT_S;
      ST_SPLIT_S:   if (!stat.s_big) state_nxt = ST_PUT_MAIN;
      ST_PUT_MAIN:  if (stat.slot_ok) state_nxt = ST_TRAIL;
      ST_TRAIL: begin
        if (stat.trail_zero) begin
          state_nxt = stat.act_flush ? ST_FLUSH_BUF : ST_DRAIN;
        end
      end
      ST_FLUSH_BUF: if (stat.slot_ok) state_nxt = ST_FLUSH_REQ;
      ST_FLUSH_REQ: if (stat.slot_ok) state_nxt = ST_DRAIN;
      ST_DRAIN:     if (stat.slot_ok) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      ST_DIV_P: begin
        cmd.div_step = !stat.div_done;
        cmd.p_store  = stat.div_done;
      end
      ST_DIV_S: begin
        cmd.div_step = !stat.div_done;
        cmd.s_store  = stat.div_done;
      end
      ST_SPLIT_P:   cmd.split_p   = stat.p_big && stat.slot_ok;
      ST_SPLIT_S:   cmd.split_s   = stat.s_big;
      ST_PUT_MAIN:  cmd.put_main  = stat.slot_ok;
      ST_TRAIL:     cmd.put_trail = !stat.trail_zero && stat.slot_ok;
      ST_FLUSH_BUF: cmd.flush_buf = stat.slot_ok;
      ST_FLUSH_REQ: cmd.flush_req = stat.slot_ok;
      ST_DRAIN:     cmd.drain     = stat.slot_ok;
      default:      cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/irpk_dp.sv
// Datapath of the IR packer: reciprocal unit conversion, chunk splitting,
// pair buffer, one-item hold stage and output register. Depends on irpk_pkg.
`default_nettype none

module irpk_dp
  import irpk_pkg::*;
#(
  parameter int MAX_CHUNKS = 60
) (
  input  wire                clk,
  input  wire                rst_n,
  input  irpk_cmd_t          cmd,
  output irpk_stat_t         stat,
  input  wire                in_action,
  input  wire  [DUR_W-1:0]   in_duration_us,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_request_kind,
  output logic [PAIR_W-1:0]  out_newer_pair,
  output logic [PAIR_W-1:0]  out_older_pair,
  output logic               out_last
);

  localparam int CAP     = MAX_CHUNKS * CHUNK_UNITS;
  localparam int UW      = $clog2(CAP + 1);
  localparam int TW      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int SAT_NUM = (CAP + 1) * UNIT_DIV;

  // Sequence state
  logic [DUR_W-1:0]  held_us_r, space_us_r;
  logic              exp_space_r, act_r;
  logic [BYTE_W-1:0] pend_p_r, pend_s_r;

  // Unit conversion
  logic [NUM_W-1:0]  num_r;
  logic [UW-1:0]     quo_r;
  logic              sat_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [NUM_W-1:0]  num_p, num_s;
  logic [PROD_W-1:0] prod;
  logic [UW-1:0]     units_clamp;

  // Split
  logic [UW-1:0] p_r, s_r;
  logic [TW-1:0] trail_r;

  // Hold and output stages
  logic              hold_valid_r;
  logic              hold_kind_r;
  logic [PAIR_W-1:0] hold_new_r, hold_old_r;
  logic              out_valid_r, out_kind_r, out_last_r;
  logic [PAIR_W-1:0] out_new_r, out_old_r;

  logic              out_free, pend_nz, put_en, emit_en, move_out;
  logic [BYTE_W-1:0] put_p, put_s;
  logic              emit_kind;
  logic [PAIR_W-1:0] emit_new, emit_old;

  assign num_p = NUM_W'(held_us_r) * NUM_W'(US_SCALE) + NUM_W'(ROUND_BIAS);
  assign num_s = NUM_W'(space_us_r) * NUM_W'(US_SCALE) + NUM_W'(ROUND_BIAS);

  // Below the saturation point the numerator fits LOW_W bits
  assign prod = PROD_W'(num_r[LOW_W-1:0]) * PROD_W'(RECIP_MULT);

  assign units_clamp = sat_r ? UW'(CAP) : quo_r;

  assign out_free = !out_valid_r || out_ready;
  assign pend_nz  = (pend_p_r != '0) || (pend_s_r != '0);

  always_comb begin
    put_en = cmd.split_p || cmd.put_main || cmd.put_trail;
    put_p  = '0;
    put_s  = '0;
    if (cmd.split_p) begin
      put_p = BYTE_W'(CHUNK_UNITS);
    end else if (cmd.put_main) begin
      put_p = p_r[BYTE_W-1:0];
      put_s = s_r[BYTE_W-1:0];
    end else if (cmd.put_trail) begin
      put_s = BYTE_W'(CHUNK_UNITS);
    end
    emit_en   = ((put_en || cmd.flush_buf) && pend_nz) || cmd.flush_req;
    emit_kind = cmd.flush_req ? REQ_FLUSH : REQ_SEND;
    emit_new  = put_en ? {put_s, put_p} : '0;
    emit_old  = cmd.flush_req ? '0 : {pend_s_r, pend_p_r};
    move_out  = (emit_en || cmd.drain) && hold_valid_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_us_r    <= '0;
      exp_space_r  <= 1'b0;
      act_r        <= ACT_VALUE;
      pend_p_r     <= '0;
      pend_s_r     <= '0;
      dcnt_r       <= DCNT_W'(CONV_STEPS);
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.take_in) begin
        act_r <= in_action;
        if (in_action == ACT_VALUE && !exp_space_r) begin
          held_us_r   <= in_duration_us;
          exp_space_r <= 1'b1;
        end else begin
          held_us_r   <= '0;
          exp_space_r <= 1'b0;
        end
        if (exp_space_r) begin
          dcnt_r <= '0;
        end
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end else if (cmd.p_store) begin
        dcnt_r <= '0;
      end

      if ((put_en || cmd.flush_buf) && pend_nz) begin
        pend_p_r <= '0;
        pend_s_r <= '0;
      end else if (put_en) begin
        pend_p_r <= put_p;
        pend_s_r <= put_s;
      end

      if (emit_en) begin
        hold_valid_r <= 1'b1;
      end else if (cmd.drain) begin
        hold_valid_r <= 1'b0;
      end

      out_valid_r <= (out_valid_r && !out_ready) || move_out;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      space_us_r <= (in_action == ACT_FLUSH) ? '0 : in_duration_us;
      num_r      <= num_p;
    end else if (cmd.div_step) begin
      sat_r <= num_r >= NUM_W'(SAT_NUM);
      quo_r <= prod[RECIP_SHIFT +: UW];
    end else if (cmd.p_store) begin
      p_r   <= units_clamp;
      num_r <= num_s;
    end

    if (cmd.s_store) begin
      s_r     <= units_clamp;
      trail_r <= '0;
    end else if (cmd.split_s) begin
      s_r     <= s_r - UW'(CHUNK_UNITS);
      trail_r <= trail_r + TW'(1);
    end else if (cmd.put_trail) begin
      trail_r <= trail_r - TW'(1);
    end

    if (cmd.split_p) begin
      p_r <= p_r - UW'(CHUNK_UNITS);
    end

    if (emit_en) begin
      hold_kind_r <= emit_kind;
      hold_new_r  <= emit_new;
      hold_old_r  <= emit_old;
    end

    if (move_out) begin
      out_kind_r <= hold_kind_r;
      out_new_r  <= hold_new_r;
      out_old_r  <= hold_old_r;
      out_last_r <= cmd.drain;
    end
  end

  always_comb begin
    stat.exp_space  = exp_space_r;
    stat.in_flush   = (in_action == ACT_FLUSH);
    stat.act_flush  = (act_r == ACT_FLUSH);
    stat.div_done   = (dcnt_r == DCNT_W'(CONV_STEPS));
    stat.p_big      = p_r > UW'(CHUNK_UNITS);
    stat.s_big      = s_r > UW'(CHUNK_UNITS);
    stat.trail_zero = (trail_r == '0);
    stat.slot_ok    = !hold_valid_r || out_free;
  end

  assign out_valid        = out_valid_r;
  assign out_request_kind = out_kind_r;
  assign out_newer_pair   = out_new_r;
  assign out_older_pair   = out_old_r;
  assign out_last         = out_last_r;

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_en && hold_valid_r) |-> out_free)
    else $error("item emitted while hold and output stages are full");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_req |-> !pend_nz)
    else $error("flush request issued with a pair still buffered");

  a_store_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.p_store || cmd.s_store) |-> (units_clamp <= UW'(CAP)))
    else $error("converted units above the cap at store");

  a_drain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain |=> !hold_valid_r)
    else $error("hold stage still valid after drain");

endmodule

`default_nettype wire
